// ===== hdl/fbba_pkg.sv =====
// ----------------------------------------------------------------------------
// fbba_pkg: shared types and constants of the free block bitmap allocator
// Command codes, word widths, state machine states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fbba_pkg;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int BLOCK_W  = 12;
   localparam int COUNT_W  = 13;
   // block base counter of the scan, with room to step one word past the count
   localparam int BASE_W   = 14;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register addresses
   localparam logic [CSR_ADDR_W-1:0] REG_TOTAL_BLOCKS = 3'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_MARK_FREE = 2'd0,
      CMD_MARK_USED = 2'd1,
      CMD_TEST      = 2'd2,
      CMD_FIND      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_UPDATE,
      ST_SCAN
   } state_type;

   typedef enum logic [1:0] {
      RSP_MARK,
      RSP_BAD,
      RSP_FIND
   } rsp_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;
      logic         rd_word;
      logic         wr_word;
      logic         scan_init;
      logic         scan_step;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    bad;
      logic    hit;
      logic    scan_done;
   } dp_stat_type;

endpackage

// ===== hdl/free_block_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator: free block bitmap with first-fit search
// Requests on req_* (valid/ready) carry a command and a block number; one
// result word per request leaves on rsp_* (valid/ready) in request order.
// Commands: mark free, mark used, test block, find first free block.
// The csr_* port holds total_blocks at address 0; writing it reformats the
// map to all free and loads the free count with the new block count.
// Mark and test read one bitmap word, then write it back when the bit
// changes; a bad block number is answered without a read. Find reads the
// bitmap one word per cycle through the ram read port, at most
// MAX_BLOCKS/WORD_BITS words, and stops at the first word below the count
// that holds a free block.
// One request is in flight at a time; the next is taken once the current
// result is in the output register, even if that result is not yet taken.
// A stalled rsp_ready holds the result and stops the block at its last step.
// Reset: map all free, total_blocks = MAX_BLOCKS, free count = MAX_BLOCKS;
// per-word valid bits stand for the format, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fbba_pkg::CMD_W-1:0]          req_cmd,
   input  logic [fbba_pkg::BLOCK_W-1:0]        req_block_number,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_block_is_free,
   output logic [fbba_pkg::BLOCK_W-1:0]        rsp_found_block,
   output logic                                rsp_found,
   output logic [fbba_pkg::COUNT_W-1:0]        rsp_free_count,
   output logic                                rsp_bad_block,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fbba_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fbba_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fbba_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import fbba_pkg::*;

   dp_cmd_type          cmd;
   dp_stat_type         stat;
   logic                cfg_wr;
   logic [COUNT_W-1:0]  cfg_raw;
   logic [COUNT_W-1:0]  cfg_total;
   logic [COUNT_W-1:0]  total_blocks;
   logic                reg_sel;

   // register decode, word aligned
   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_TOTAL_BLOCKS[CSR_ADDR_W-1:2]);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;

   // block count saturates at the map size
   assign cfg_raw   = csr_pwdata[COUNT_W-1:0];
   assign cfg_total = (32'(cfg_raw) > 32'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : cfg_raw;

   // read back
   assign csr_prdata = reg_sel ? CSR_DATA_W'(total_blocks) : '0;

   fbba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   fbba_dp #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_block_number (req_block_number),
      .cfg_wr           (cfg_wr),
      .cfg_total        (cfg_total),
      .total_blocks     (total_blocks),
      .rsp_block_is_free(rsp_block_is_free),
      .rsp_found_block  (rsp_found_block),
      .rsp_found        (rsp_found),
      .rsp_free_count   (rsp_free_count),
      .rsp_bad_block    (rsp_bad_block)
   );

endmodule

// ===== hdl/fbba_ram.sv =====
// ----------------------------------------------------------------------------
// fbba_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fbba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fbba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbba_ctrl: controller of the bitmap allocator
// Sequences capture, read-modify-write, scan and result load; owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module fbba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  fbba_pkg::dp_stat_type stat,
   output fbba_pkg::dp_cmd_type  cmd
);
   import fbba_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output slot is free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // state and valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rsp_kind  = RSP_MARK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (stat.cmd == CMD_FIND) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else if (stat.bad) begin
               if (out_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_kind = RSP_BAD;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.rd_word = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.wr_word  = 1'b1;
               cmd.rsp_load = 1'b1;
               cmd.rsp_kind = RSP_MARK;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (stat.hit || stat.scan_done) begin
               if (out_free) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_kind = RSP_FIND;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// ===== hdl/fbba_dp.sv =====
// ----------------------------------------------------------------------------
// fbba_dp: datapath of the bitmap allocator
// Bitmap ram with per-word valid bits, word and bit decode, free counter,
// first-fit scan and result registers.
// ----------------------------------------------------------------------------
module fbba_dp #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbba_pkg::dp_cmd_type                cmd,
   output fbba_pkg::dp_stat_type               stat,
   input  logic [fbba_pkg::CMD_W-1:0]          req_cmd,
   input  logic [fbba_pkg::BLOCK_W-1:0]        req_block_number,
   input  logic                                cfg_wr,
   input  logic [fbba_pkg::COUNT_W-1:0]        cfg_total,
   output logic [fbba_pkg::COUNT_W-1:0]        total_blocks,
   output logic                                rsp_block_is_free,
   output logic [fbba_pkg::BLOCK_W-1:0]        rsp_found_block,
   output logic                                rsp_found,
   output logic [fbba_pkg::COUNT_W-1:0]        rsp_free_count,
   output logic                                rsp_bad_block
);
   import fbba_pkg::*;

   localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   // block / WORD_BITS as multiply by reciprocal, exact for BLOCK_W-bit blocks
   localparam int RECIP_SH   = BLOCK_W + BIT_IDX_W;
   localparam int RECIP      = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W     = BLOCK_W + RECIP_SH + 1;

   // captured item
   cmd_type                cmd_ff;
   logic [BLOCK_W-1:0]     blk_ff;
   logic [WORD_IDX_W-1:0]  word_ff;
   logic [BIT_IDX_W-1:0]   bit_ff;
   logic                   bad_ff;
   logic [PROD_W-1:0]      prod;
   logic [WORD_IDX_W-1:0]  word_calc;
   logic [BLOCK_W-1:0]     word_base;

   // configuration and count
   logic [COUNT_W-1:0]     total_ff;
   logic [COUNT_W-1:0]     free_total_ff, free_total_in;

   // map storage
   logic [MAP_WORDS-1:0]   valid_ff;
   logic                   rd_valid_ff;
   logic                   ram_re;
   logic [WORD_IDX_W-1:0]  ram_raddr;
   logic [WORD_BITS-1:0]   ram_rdata;
   logic [WORD_BITS-1:0]   cur_word;
   logic [WORD_BITS-1:0]   new_word;
   logic                   cur_bit, new_bit;
   logic                   map_wr;

   // scan
   logic [WORD_IDX_W-1:0]  iss_word_ff;
   logic [BASE_W-1:0]      iss_base_ff;
   logic [BASE_W-1:0]      chk_base_ff;
   logic                   chk_pend_ff;
   logic                   more;
   logic [BASE_W-1:0]      lim;
   logic [WORD_BITS-1:0]   lim_mask;
   logic [WORD_BITS-1:0]   masked;
   logic [WORD_BITS-1:0]   lowest;
   logic [BIT_IDX_W-1:0]   low_idx;

   // result registers
   logic                   is_free_ff;
   logic [BLOCK_W-1:0]     found_block_ff;
   logic                   found_ff;
   logic [COUNT_W-1:0]     free_count_ff;
   logic                   bad_block_ff;

   // word index of the incoming block
   assign prod      = PROD_W'(req_block_number) * PROD_W'(RECIP);
   assign word_calc = WORD_IDX_W'(prod >> RECIP_SH);
   assign word_base = BLOCK_W'(BLOCK_W'(word_ff) * BLOCK_W'(WORD_BITS));

   // capture and bit offset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= cmd_type'(req_cmd);
         blk_ff  <= req_block_number;
         word_ff <= word_calc;
         bad_ff  <= {1'b0, req_block_number} >= total_ff;
      end
      if (cmd.rd_word) begin
         bit_ff <= BIT_IDX_W'(blk_ff - word_base);
      end
   end

   // ram read port shared by read-modify-write and scan
   assign more      = iss_base_ff < BASE_W'(total_ff);
   assign ram_re    = cmd.rd_word || (cmd.scan_step && more);
   assign ram_raddr = cmd.rd_word ? word_ff : iss_word_ff;

   fbba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS),
      .ADDR_W(WORD_IDX_W)
   ) u_map (
      .clock  (clock),
      .wr_en  (map_wr),
      .wr_addr(word_ff),
      .wr_data(new_word),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // a word never written since format reads as all free
   assign cur_word = rd_valid_ff ? ram_rdata : '1;

   // read-modify-write of the addressed bit
   always_comb begin
      cur_bit  = cur_word[bit_ff];
      new_bit  = cur_bit;
      unique case (cmd_ff)
         CMD_MARK_FREE: new_bit = 1'b1;
         CMD_MARK_USED: new_bit = 1'b0;
         CMD_TEST:      new_bit = cur_bit;
         CMD_FIND:      new_bit = cur_bit;
         default:       new_bit = cur_bit;
      endcase
      new_word         = cur_word;
      new_word[bit_ff] = new_bit;
   end

   assign map_wr = cmd.wr_word && (new_bit != cur_bit);

   // free count follows actual bit flips
   always_comb begin
      free_total_in = free_total_ff;
      if (map_wr) begin
         if (new_bit) begin
            free_total_in = free_total_ff + COUNT_W'(1);
         end else begin
            free_total_in = free_total_ff - COUNT_W'(1);
         end
      end
   end

   // configuration, count and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= COUNT_W'(MAX_BLOCKS);
         free_total_ff <= COUNT_W'(MAX_BLOCKS);
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
      end else if (cfg_wr) begin
         total_ff      <= cfg_total;
         free_total_ff <= cfg_total;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         free_total_ff <= free_total_in;
         if (map_wr) begin
            valid_ff[word_ff] <= 1'b1;
         end
         if (ram_re) begin
            rd_valid_ff <= valid_ff[ram_raddr];
         end
      end
   end

   // scan pointers: issue one word a cycle, check the one issued before
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_pend_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         chk_pend_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         chk_pend_ff <= more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         iss_word_ff <= '0;
         iss_base_ff <= '0;
      end else if (cmd.scan_step && more) begin
         iss_word_ff <= iss_word_ff + WORD_IDX_W'(1);
         iss_base_ff <= iss_base_ff + BASE_W'(WORD_BITS);
         chk_base_ff <= iss_base_ff;
      end
   end

   // keep only blocks below the count in the checked word
   assign lim = BASE_W'(total_ff) - chk_base_ff;

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         lim_mask[j] = BASE_W'(j) < lim;
      end
   end

   assign masked = cur_word & lim_mask;
   assign lowest = masked & (~masked + WORD_BITS'(1));

   // one-hot lowest free bit to index
   always_comb begin
      low_idx = '0;
      for (int k = 0; k < BIT_IDX_W; k++) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            if (((j >> k) & 1) == 1) begin
               low_idx[k] = low_idx[k] | lowest[j];
            end
         end
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_kind)
            RSP_MARK: begin
               is_free_ff     <= new_bit;
               found_block_ff <= '0;
               found_ff       <= 1'b0;
               bad_block_ff   <= 1'b0;
            end
            RSP_BAD: begin
               is_free_ff     <= 1'b0;
               found_block_ff <= '0;
               found_ff       <= 1'b0;
               bad_block_ff   <= 1'b1;
            end
            RSP_FIND: begin
               is_free_ff     <= 1'b0;
               found_block_ff <= stat.hit ? BLOCK_W'(chk_base_ff + BASE_W'(low_idx)) : '0;
               found_ff       <= stat.hit;
               bad_block_ff   <= 1'b0;
            end
            default: begin
               is_free_ff     <= 1'b0;
               found_block_ff <= '0;
               found_ff       <= 1'b0;
               bad_block_ff   <= 1'b0;
            end
         endcase
         free_count_ff <= free_total_in;
      end
   end

   // status to controller
   assign stat.cmd       = cmd_ff;
   assign stat.bad       = bad_ff;
   assign stat.hit       = chk_pend_ff && (masked != '0);
   assign stat.scan_done = !chk_pend_ff && !more;

   assign total_blocks      = total_ff;
   assign rsp_block_is_free = is_free_ff;
   assign rsp_found_block   = found_block_ff;
   assign rsp_found         = found_ff;
   assign rsp_free_count    = free_count_ff;
   assign rsp_bad_block     = bad_block_ff;

endmodule

// ===== tb/sv/tb_free_block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_block_bitmap_allocator: self-checking bench for the bitmap allocator
// Request words are queued by a stimulus process and sent by a clocked driver
// with random gaps. A clocked monitor takes result words with random stalls
// and checks every field against an in-bench bitmap predictor. The block
// count register is rewritten between phases, extremes and saturation
// included; one phase opens with a long result hold-off to back up the input.
// ----------------------------------------------------------------------------
module tb_free_block_bitmap_allocator;
   import fbba_pkg::*;

   localparam int MAP_BITS        = 4096;
   localparam int STALL_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 30;
   localparam int NUM_PHASES      = 10;
   // index 1 lies past the register list and must be ignored
   localparam logic [CSR_ADDR_W-1:0] SPARE_REG_ADDR = 3'd4;

   typedef struct packed {
      cmd_type              cmd;
      logic [BLOCK_W-1:0]   blk;
   } alloc_req_type;

   typedef struct packed {
      logic                 is_free;
      logic [BLOCK_W-1:0]   found_block;
      logic                 found;
      logic [COUNT_W-1:0]   free_count;
      logic                 bad;
   } alloc_rsp_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // block ports
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd          = '0;
   logic [BLOCK_W-1:0]    req_block_number = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic                  rsp_block_is_free;
   logic [BLOCK_W-1:0]    rsp_found_block;
   logic                  rsp_found;
   logic [COUNT_W-1:0]    rsp_free_count;
   logic                  rsp_bad_block;
   logic                  csr_psel         = 1'b0;
   logic                  csr_penable      = 1'b0;
   logic                  csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr        = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   free_block_bitmap_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_block_number  (req_block_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_block_is_free (rsp_block_is_free),
      .rsp_found_block   (rsp_found_block),
      .rsp_found         (rsp_found),
      .rsp_free_count    (rsp_free_count),
      .rsp_bad_block     (rsp_bad_block),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // predictor state: one bit per block, 1 meaning free
   logic [MAP_BITS-1:0] free_bits    = '1;
   int                  free_total   = MAP_BITS;
   int                  block_count  = MAP_BITS;

   alloc_req_type pending_reqs[$];
   alloc_rsp_type expected_rsps[$];
   alloc_req_type next_req;
   alloc_rsp_type want;

   int reqs_queued   = 0;
   int rsp_seen      = 0;
   int error_count   = 0;
   int cfg_writes    = 0;
   int finds_hit     = 0;
   int finds_empty   = 0;
   int bad_numbers   = 0;
   int tx_gap        = 0;
   int tx_calm       = 0;
   int rx_gap        = 0;
   int rx_calm       = 0;
   int rx_draw       = 0;
   int stall_left    = 0;
   int idle_cycles   = 0;
   logic stall_request = 1'b0;
   logic stall_taken   = 1'b0;

   int phase_total [NUM_PHASES] = '{4096, 160, 513, 37, 1, 4095, 64, 2, 1000, 4096};
   int phase_items [NUM_PHASES] = '{200, 400, 300, 150, 40, 150, 120, 30, 90, 50};

   // one command applied to the predicted bitmap
   function automatic alloc_rsp_type bitmap_step(input cmd_type cmd,
                                                 input logic [BLOCK_W-1:0] blk);
      alloc_rsp_type r;
      r = '0;
      if (cmd == CMD_FIND) begin
         for (int i = 0; i < block_count; i++) begin
            if (free_bits[i]) begin
               r.found       = 1'b1;
               r.found_block = BLOCK_W'(i);
               break;
            end
         end
         if (r.found) finds_hit++;
         else finds_empty++;
      end else if (int'(blk) >= block_count) begin
         r.bad = 1'b1;
         bad_numbers++;
      end else begin
         if (cmd == CMD_MARK_FREE && !free_bits[blk]) begin
            free_bits[blk] = 1'b1;
            free_total++;
         end else if (cmd == CMD_MARK_USED && free_bits[blk]) begin
            free_bits[blk] = 1'b0;
            free_total--;
         end
         r.is_free = free_bits[blk];
      end
      r.free_count = COUNT_W'(free_total);
      return r;
   endfunction

   // gap length: mostly short, a few long, with calm stretches of none
   function automatic int draw_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 120);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on %s: got 0x%0h, want 0x%0h (result %0d)",
                  what, got, exp_val, rsp_seen);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(bitmap_step(cmd_type'(req_cmd), req_block_number));
         if (!req_valid || req_ready) begin
            if (tx_gap != 0) begin
               tx_gap    <= tx_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               next_req          = pending_reqs.pop_front();
               req_valid        <= 1'b1;
               req_cmd          <= next_req.cmd;
               req_block_number <= next_req.blk;
               tx_gap           <= draw_gap(tx_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result word", 32'd1, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_block_is_free !== want.is_free)
                  report_mismatch("block_is_free", rsp_block_is_free, want.is_free);
               if (rsp_found_block !== want.found_block)
                  report_mismatch("found_block", rsp_found_block, want.found_block);
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_free_count !== want.free_count)
                  report_mismatch("free_count", rsp_free_count, want.free_count);
               if (rsp_bad_block !== want.bad)
                  report_mismatch("bad_block", rsp_bad_block, want.bad);
            end
            rsp_seen++;
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (stall_request && !stall_taken) begin
            stall_taken <= 1'b1;
            stall_left  <= STALL_CYCLES;
            rsp_ready   <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap    <= rx_gap - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rx_draw    = draw_gap(rx_calm);
            rx_gap    <= rx_draw;
            rsp_ready <= (rx_draw == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake on any port
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("tb_free_block_bitmap_allocator: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_item(input cmd_type cmd, input logic [BLOCK_W-1:0] blk);
      alloc_req_type q;
      q.cmd = cmd;
      q.blk = blk;
      pending_reqs.push_back(q);
      reqs_queued++;
   endtask

   // register write: setup then access, predictor updated at the write edge
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      int value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_writes++;
      if (addr == REG_TOTAL_BLOCKS) begin
         value = int'(data[COUNT_W-1:0]);
         if (value > MAP_BITS) value = MAP_BITS;
         block_count = value;
         free_bits   = '1;
         free_total  = value;
      end
   endtask

   // wait until every queued request has its result back
   task automatic wait_idle();
      while (rsp_seen < reqs_queued) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int span;
      int fill_ptr;
      int r;
      int lo;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset state, repeated marks, extremes of the block number
      queue_item(CMD_TEST, 12'd0);
      queue_item(CMD_FIND, 12'd0);
      queue_item(CMD_MARK_USED, 12'd0);
      queue_item(CMD_MARK_USED, 12'd0);
      queue_item(CMD_FIND, 12'd0);
      queue_item(CMD_MARK_USED, 12'hFFF);
      queue_item(CMD_TEST, 12'hFFF);
      queue_item(CMD_TEST, 12'hAAA);
      queue_item(CMD_MARK_FREE, 12'd0);
      queue_item(CMD_MARK_FREE, 12'h555);
      queue_item(CMD_FIND, 12'hFFF);

      // single block: bad numbers, then a full map
      wait_idle();
      csr_write(REG_TOTAL_BLOCKS, 32'd1);
      queue_item(CMD_TEST, 12'd0);
      queue_item(CMD_TEST, 12'd1);
      queue_item(CMD_MARK_USED, 12'hFFF);
      queue_item(CMD_MARK_USED, 12'd0);
      queue_item(CMD_FIND, 12'd0);
      queue_item(CMD_MARK_FREE, 12'd1);

      // zero blocks: everything bad, find empty
      wait_idle();
      csr_write(REG_TOTAL_BLOCKS, 32'd0);
      queue_item(CMD_FIND, 12'd0);
      queue_item(CMD_TEST, 12'd0);

      // count above the maximum saturates
      wait_idle();
      csr_write(REG_TOTAL_BLOCKS, 32'h0000_1FFF);
      queue_item(CMD_TEST, 12'hFFF);
      queue_item(CMD_FIND, 12'd0);

      // upper data bits are dropped, then a write past the register list
      wait_idle();
      csr_write(REG_TOTAL_BLOCKS, 32'hFFFF_E005);
      queue_item(CMD_TEST, 12'd5);
      queue_item(CMD_MARK_USED, 12'd4);
      wait_idle();
      csr_write(SPARE_REG_ADDR, 32'd3);
      queue_item(CMD_TEST, 12'd4);
      queue_item(CMD_FIND, 12'd0);

      // random phases: prefix fill drives finds deep, plus noise
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         csr_write(REG_TOTAL_BLOCKS, phase_total[p]);
         if (p == 0) stall_request <= 1'b1;
         span     = phase_total[p];
         fill_ptr = 0;
         for (int n = 0; n < phase_items[p]; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               queue_item(cmd_type'($urandom_range(0, 3)), BLOCK_W'($urandom_range(0, 4095)));
            end else if (r < 45) begin
               queue_item(CMD_MARK_USED, BLOCK_W'(fill_ptr));
               fill_ptr = (fill_ptr + 1) % span;
            end else if (r < 57) begin
               lo = ($urandom_range(0, 99) < 80) ? fill_ptr : 0;
               queue_item(CMD_MARK_FREE, BLOCK_W'($urandom_range(lo, span - 1)));
            end else if (r < 65) begin
               queue_item(CMD_MARK_USED, BLOCK_W'($urandom_range(0, span - 1)));
            end else if (r < 80) begin
               queue_item(CMD_TEST, BLOCK_W'($urandom_range(0, span - 1)));
            end else begin
               queue_item(CMD_FIND, BLOCK_W'($urandom_range(0, 4095)));
            end
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("results never returned", expected_rsps.size(), 32'd0);

      $display("covered %0d requests across %0d register writes", reqs_queued, cfg_writes);
      $display("finds with a hit %0d, finds on a full map %0d, bad block numbers %0d",
               finds_hit, finds_empty, bad_numbers);
      if (error_count == 0) begin
         $display("tb_free_block_bitmap_allocator: done, clean");
      end else begin
         $display("tb_free_block_bitmap_allocator: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/fbba_pkg.sv
hdl/fbba_ram.sv
hdl/fbba_ctrl.sv
hdl/fbba_dp.sv
hdl/free_block_bitmap_allocator.sv
tb/sv/tb_free_block_bitmap_allocator.sv
